// ===== rtl/versioned_key_value_lookup_assert.svh =====
// Assertion macros for the versioned key-value lookup.
// Included by the top level; no other dependencies.
`ifndef VERSIONED_KEY_VALUE_LOOKUP_ASSERT_SVH
`define VERSIONED_KEY_VALUE_LOOKUP_ASSERT_SVH

// same-cycle implication
`define VKV_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("vkv: implication check failed");

// next-cycle implication
`define VKV_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("vkv: next-cycle check failed");

`endif

// ===== rtl/vkv_pkg.sv =====
// Shared types and constants for the versioned key-value lookup.
// No dependencies; used by vkv_cell, the top level and the testbench.
`timescale 1ns / 1ps

package vkv_pkg;

    localparam int ENTRIES_DEF    = 256;
    localparam int KEY_BITS_DEF   = 32;
    localparam int VALUE_BITS_DEF = 32;

    localparam int KEY_PORT_BITS   = 32;
    localparam int VALUE_PORT_BITS = 32;
    localparam int TIME_BITS       = 31;

    typedef enum logic [1:0] {
        ST_STORED    = 2'd0,
        ST_FOUND     = 2'd1,
        ST_NOT_FOUND = 2'd2,
        ST_FULL      = 2'd3
    } vkv_status_t;

    // control part of the query token that walks the cell row
    typedef struct packed {
        logic valid;
        logic hit;
    } vkv_ctl_t;

endpackage

// ===== rtl/vkv_cell.sv =====
// One cell of the entry row: holds one stored entry and one stage of the query token.
// Depends on vkv_pkg. Entries shift to higher cells on every store while not full.
`timescale 1ns / 1ps

module vkv_cell #(
    parameter int KEY_BITS   = 32,
    parameter int VALUE_BITS = 32,
    parameter int CNT_BITS   = 9
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      shift_en,
    input  logic [KEY_BITS-1:0]       i_ent_key,
    input  logic [vkv_pkg::TIME_BITS-1:0] i_ent_time,
    input  logic [VALUE_BITS-1:0]     i_ent_data,
    output logic [KEY_BITS-1:0]       o_ent_key,
    output logic [vkv_pkg::TIME_BITS-1:0] o_ent_time,
    output logic [VALUE_BITS-1:0]     o_ent_data,
    input  vkv_pkg::vkv_ctl_t         i_ctl,
    input  logic [KEY_BITS-1:0]       i_qkey,
    input  logic [vkv_pkg::TIME_BITS-1:0] i_qtime,
    input  logic [CNT_BITS-1:0]       i_remain,
    input  logic [vkv_pkg::TIME_BITS-1:0] i_best_time,
    input  logic [VALUE_BITS-1:0]     i_best_data,
    output vkv_pkg::vkv_ctl_t         o_ctl,
    output logic [KEY_BITS-1:0]       o_qkey,
    output logic [vkv_pkg::TIME_BITS-1:0] o_qtime,
    output logic [CNT_BITS-1:0]       o_remain,
    output logic [vkv_pkg::TIME_BITS-1:0] o_best_time,
    output logic [VALUE_BITS-1:0]     o_best_data
);
    import vkv_pkg::*;

    logic [KEY_BITS-1:0]   ent_key_reg;
    logic [TIME_BITS-1:0]  ent_time_reg;
    logic [VALUE_BITS-1:0] ent_data_reg;

    vkv_ctl_t              ctl_reg, ctl_next;
    logic [KEY_BITS-1:0]   qkey_reg;
    logic [TIME_BITS-1:0]  qtime_reg;
    logic [CNT_BITS-1:0]   remain_reg, remain_next;
    logic [TIME_BITS-1:0]  best_time_reg, best_time_next;
    logic [VALUE_BITS-1:0] best_data_reg, best_data_next;

    logic active;
    logic match;
    logic take;

    // newest entry sits in the lowest cell, so on equal times keep what was found first
    always_comb begin
        active         = i_ctl.valid && (i_remain != '0);
        match          = active && (ent_key_reg == i_qkey) && (ent_time_reg <= i_qtime);
        take           = match && (!i_ctl.hit || (ent_time_reg > i_best_time));
        ctl_next.valid = i_ctl.valid;
        ctl_next.hit   = i_ctl.hit || match;
        remain_next    = active ? i_remain - CNT_BITS'(1) : i_remain;
        best_time_next = take ? ent_time_reg : i_best_time;
        best_data_next = take ? ent_data_reg : i_best_data;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctl_reg <= '0;
        end else begin
            ctl_reg <= ctl_next;
        end
    end

    always_ff @(posedge aclk) begin
        qkey_reg      <= i_qkey;
        qtime_reg     <= i_qtime;
        remain_reg    <= remain_next;
        best_time_reg <= best_time_next;
        best_data_reg <= best_data_next;
        if (shift_en) begin
            ent_key_reg  <= i_ent_key;
            ent_time_reg <= i_ent_time;
            ent_data_reg <= i_ent_data;
        end
    end

    assign o_ent_key   = ent_key_reg;
    assign o_ent_time  = ent_time_reg;
    assign o_ent_data  = ent_data_reg;
    assign o_ctl       = ctl_reg;
    assign o_qkey      = qkey_reg;
    assign o_qtime     = qtime_reg;
    assign o_remain    = remain_reg;
    assign o_best_time = best_time_reg;
    assign o_best_data = best_data_reg;

endmodule

// ===== rtl/versioned_key_value_lookup.sv =====
// Store: the status is registered at transfer and goes via S_DONE to the output.
// Lookup: the query walks the row of ENTRIES cells, one cell a cycle; the result is
// captured from the row's end in S_SCAN and goes via S_DONE to the output.
// One item is in flight at a time; the output register holds a result until taken.
// Reset empties the table (entry count cleared) and drops any pending result.
`timescale 1ns / 1ps

module versioned_key_value_lookup #(
    parameter int ENTRIES    = vkv_pkg::ENTRIES_DEF,
    parameter int KEY_BITS   = vkv_pkg::KEY_BITS_DEF,
    parameter int VALUE_BITS = vkv_pkg::VALUE_BITS_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic                               s_mode,
    input  logic [vkv_pkg::KEY_PORT_BITS-1:0]  s_key,
    input  logic [vkv_pkg::VALUE_PORT_BITS-1:0] s_value,
    input  logic [vkv_pkg::TIME_BITS-1:0]      s_timestamp,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic [1:0]                         m_status,
    output logic [vkv_pkg::VALUE_PORT_BITS-1:0] m_found_value
);
    import vkv_pkg::*;

    `include "versioned_key_value_lookup_assert.svh"

    localparam int CNT_BITS = $clog2(ENTRIES + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DONE
    } state_t;

    state_t                     state_reg;
    logic [CNT_BITS-1:0]        count_reg;
    vkv_status_t                res_status_reg;
    logic [VALUE_PORT_BITS-1:0] res_value_reg;
    logic                       m_valid_reg;
    vkv_status_t                m_status_reg;
    logic [VALUE_PORT_BITS-1:0] m_value_reg;

    logic accept;
    logic full;
    logic shift_en;

    logic [KEY_BITS-1:0]   key_in;
    logic [VALUE_BITS-1:0] data_in;

    logic [KEY_BITS-1:0]   ent_key   [0:ENTRIES];
    logic [TIME_BITS-1:0]  ent_time  [0:ENTRIES];
    logic [VALUE_BITS-1:0] ent_data  [0:ENTRIES];
    vkv_ctl_t              tok_ctl   [0:ENTRIES];
    logic [KEY_BITS-1:0]   tok_key   [0:ENTRIES];
    logic [TIME_BITS-1:0]  tok_time  [0:ENTRIES];
    logic [CNT_BITS-1:0]   tok_rem   [0:ENTRIES];
    logic [TIME_BITS-1:0]  tok_btime [0:ENTRIES];
    logic [VALUE_BITS-1:0] tok_bdata [0:ENTRIES];

    assign s_ready  = (state_reg == S_IDLE);
    assign accept   = s_valid && s_ready;
    assign full     = (count_reg == CNT_BITS'(ENTRIES));
    assign shift_en = accept && !s_mode && !full;
    assign key_in   = KEY_BITS'(s_key);
    assign data_in  = VALUE_BITS'(s_value);

    // new entry enters at the head of the row
    assign ent_key[0]  = key_in;
    assign ent_time[0] = s_timestamp;
    assign ent_data[0] = data_in;

    // query token injected into the head of the row
    assign tok_ctl[0].valid = accept && s_mode;
    assign tok_ctl[0].hit   = 1'b0;
    assign tok_key[0]       = key_in;
    assign tok_time[0]      = s_timestamp;
    assign tok_rem[0]       = count_reg;
    assign tok_btime[0]     = '0;
    assign tok_bdata[0]     = '0;

    for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
        vkv_cell #(
            .KEY_BITS   (KEY_BITS),
            .VALUE_BITS (VALUE_BITS),
            .CNT_BITS   (CNT_BITS)
        ) u_cell (
            .aclk        (aclk),
            .aresetn     (aresetn),
            .shift_en    (shift_en),
            .i_ent_key   (ent_key[i]),
            .i_ent_time  (ent_time[i]),
            .i_ent_data  (ent_data[i]),
            .o_ent_key   (ent_key[i+1]),
            .o_ent_time  (ent_time[i+1]),
            .o_ent_data  (ent_data[i+1]),
            .i_ctl       (tok_ctl[i]),
            .i_qkey      (tok_key[i]),
            .i_qtime     (tok_time[i]),
            .i_remain    (tok_rem[i]),
            .i_best_time (tok_btime[i]),
            .i_best_data (tok_bdata[i]),
            .o_ctl       (tok_ctl[i+1]),
            .o_qkey      (tok_key[i+1]),
            .o_qtime     (tok_time[i+1]),
            .o_remain    (tok_rem[i+1]),
            .o_best_time (tok_btime[i+1]),
            .o_best_data (tok_bdata[i+1])
        );
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            count_reg      <= '0;
            res_status_reg <= ST_STORED;
            res_value_reg  <= '0;
            m_valid_reg    <= 1'b0;
            m_status_reg   <= ST_STORED;
            m_value_reg    <= '0;
        end else begin
            if (m_valid_reg && m_ready && (state_reg != S_DONE)) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE: begin
                    if (accept) begin
                        res_value_reg <= '0;
                        if (s_mode) begin
                            state_reg <= S_SCAN;
                        end else begin
                            state_reg      <= S_DONE;
                            res_status_reg <= full ? ST_FULL : ST_STORED;
                            if (!full) begin
                                count_reg <= count_reg + CNT_BITS'(1);
                            end
                        end
                    end
                end
                S_SCAN: begin
                    if (tok_ctl[ENTRIES].valid) begin
                        state_reg      <= S_DONE;
                        res_status_reg <= tok_ctl[ENTRIES].hit ? ST_FOUND : ST_NOT_FOUND;
                        res_value_reg  <= tok_ctl[ENTRIES].hit ?
                                          VALUE_PORT_BITS'(tok_bdata[ENTRIES]) : '0;
                    end
                end
                S_DONE: begin
                    if (!m_valid_reg || m_ready) begin
                        state_reg    <= S_IDLE;
                        m_valid_reg  <= 1'b1;
                        m_status_reg <= res_status_reg;
                        m_value_reg  <= res_value_reg;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_status      = m_status_reg;
    assign m_found_value = m_value_reg;

    `VKV_ASSERT_IMP(a_count_bound, aclk, aresetn, 1'b1, count_reg <= CNT_BITS'(ENTRIES))
    `VKV_ASSERT_IMP(a_exit_in_scan, aclk, aresetn, tok_ctl[ENTRIES].valid, state_reg == S_SCAN)
    `VKV_ASSERT_NXT(a_store_count, aclk, aresetn, shift_en, count_reg == $past(count_reg) + CNT_BITS'(1))
    `VKV_ASSERT_IMP(a_zero_value, aclk, aresetn, m_valid && (m_status != ST_FOUND), m_found_value == '0)

endmodule

// ===== sim/tb_versioned_key_value_lookup.sv =====
// Self-checking testbench for versioned_key_value_lookup: stores and lookups,
// random idling on both channels, a long output hold-off and a full table.
// Depends on vkv_pkg and the versioned_key_value_lookup RTL.
`timescale 1ns / 1ps

module tb_versioned_key_value_lookup;
    import vkv_pkg::*;

    localparam int         SLOTS        = ENTRIES_DEF;
    localparam int         RANDOM_ITEMS = 830;
    localparam int         POOL_SIZE    = 8;
    localparam int         CYCLE_LIMIT  = 2_500_000;
    localparam int         HOLD_AT      = 300;
    localparam int         HOLD_CYCLES  = 600;
    localparam logic       MODE_STORE   = 1'b0;
    localparam logic       MODE_LOOKUP  = 1'b1;
    localparam logic [30:0] TIME_MAX    = '1;

    typedef struct {
        logic        mode;
        logic [31:0] key;
        logic [31:0] value;
        logic [30:0] stamp;
    } kv_request_t;

    typedef struct {
        vkv_status_t status;
        logic [31:0] value;
    } kv_result_t;

    logic        aclk          = 1'b0;
    logic        aresetn       = 1'b0;
    logic        s_valid       = 1'b0;
    logic        s_ready;
    logic        s_mode        = MODE_STORE;
    logic [31:0] s_key         = '0;
    logic [31:0] s_value       = '0;
    logic [30:0] s_timestamp   = '0;
    logic        m_valid;
    logic        m_ready       = 1'b0;
    logic [1:0]  m_status;
    logic [31:0] m_found_value;

    kv_request_t pending_requests[$];
    kv_result_t  expected_results[$];
    kv_request_t offered;

    logic [31:0] slot_key  [SLOTS];
    logic [30:0] slot_time [SLOTS];
    logic [31:0] slot_data [SLOTS];
    int          slot_count = 0;

    logic [31:0] key_pool [POOL_SIZE];

    int   accepted_count = 0;
    int   checked_count  = 0;
    int   total_items    = 0;
    int   failures       = 0;
    int   cycle_count    = 0;
    int   gap_left       = 0;
    int   stall_left     = 0;
    int   hold_left      = 0;
    logic hold_done      = 1'b0;
    logic quiet;

    assign quiet = ((accepted_count / 64) % 4) == 1;

    versioned_key_value_lookup #(
        .ENTRIES    (SLOTS),
        .KEY_BITS   (KEY_BITS_DEF),
        .VALUE_BITS (VALUE_BITS_DEF)
    ) uut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_mode        (s_mode),
        .s_key         (s_key),
        .s_value       (s_value),
        .s_timestamp   (s_timestamp),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_status      (m_status),
        .m_found_value (m_found_value)
    );

    always #5 aclk = ~aclk;

    function automatic kv_result_t store_or_lookup(kv_request_t req);
        kv_result_t  res;
        logic        hit;
        logic [30:0] best_time;
        res.status = ST_STORED;
        res.value  = '0;
        hit        = 1'b0;
        best_time  = '0;
        if (req.mode == MODE_STORE) begin
            if (slot_count >= SLOTS) begin
                res.status = ST_FULL;
            end else begin
                slot_key[slot_count]  = req.key;
                slot_time[slot_count] = req.stamp;
                slot_data[slot_count] = req.value;
                slot_count++;
            end
        end else begin
            for (int i = 0; i < slot_count; i++) begin
                if (slot_key[i] == req.key && slot_time[i] <= req.stamp
                        && (!hit || slot_time[i] >= best_time)) begin
                    hit       = 1'b1;
                    best_time = slot_time[i];
                    res.value = slot_data[i];
                end
            end
            res.status = hit ? ST_FOUND : ST_NOT_FOUND;
        end
        return res;
    endfunction

    function automatic int pick_gap(logic no_idle);
        int roll;
        roll = $urandom_range(99);
        if (no_idle || roll < 55)
            return 0;
        if (roll < 93)
            return $urandom_range(3, 1);
        return $urandom_range(120, 20);
    endfunction

    function automatic kv_request_t random_request();
        kv_request_t req;
        int          roll;
        req.mode  = ($urandom_range(99) < 55) ? MODE_STORE : MODE_LOOKUP;
        req.value = $urandom();
        roll      = $urandom_range(99);
        if (roll < 80)
            req.key = key_pool[$urandom_range(POOL_SIZE - 1)];
        else
            req.key = $urandom();
        roll = $urandom_range(99);
        if (roll < 70)
            req.stamp = 31'($urandom_range(15));
        else if (roll < 92)
            req.stamp = 31'($urandom());
        else
            req.stamp = roll[0] ? TIME_MAX : '0;
        return req;
    endfunction

    task automatic queue_request(logic mode, logic [31:0] key, logic [31:0] value,
                                 logic [30:0] stamp);
        kv_request_t req;
        req.mode  = mode;
        req.key   = key;
        req.value = value;
        req.stamp = stamp;
        pending_requests.insert(pending_requests.size(), req);
    endtask

    task automatic note_failure(string msg);
        failures++;
        if (failures <= 10)
            $display("[%0t] mismatch: %s", $time, msg);
    endtask

    // drive the input channel from the pending queue
    always @(posedge aclk) begin : drive_requests
        logic next_valid;
        if (!aresetn) begin
            s_valid  <= 1'b0;
            gap_left = 0;
        end else begin
            next_valid = s_valid;
            if (s_valid && s_ready) begin
                expected_results.insert(expected_results.size(), store_or_lookup(offered));
                accepted_count <= accepted_count + 1;
                next_valid = 1'b0;
            end
            if (!next_valid) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (pending_requests.size() != 0) begin
                    offered = pending_requests.pop_front();
                    s_mode      <= offered.mode;
                    s_key       <= offered.key;
                    s_value     <= offered.value;
                    s_timestamp <= offered.stamp;
                    next_valid  = 1'b1;
                    gap_left    = pick_gap(quiet);
                end
            end
            s_valid <= next_valid;
        end
    end

    // hold the result channel off once, long enough to back up the input
    always @(posedge aclk) begin
        if (aresetn && !hold_done && accepted_count == HOLD_AT) begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // accept and check results
    always @(posedge aclk) begin : check_results
        kv_result_t want;
        logic       take;
        if (aresetn && m_valid && m_ready) begin
            checked_count++;
            if (expected_results.size() == 0) begin
                note_failure($sformatf("unexpected transfer status=%0d value=%08h",
                                       m_status, m_found_value));
            end else begin
                want = expected_results.pop_front();
                if (m_status !== want.status || m_found_value !== want.value)
                    note_failure($sformatf("status exp %0d got %0d, value exp %08h got %08h",
                                           want.status, m_status, want.value,
                                           m_found_value));
            end
        end
        if (stall_left > 0) begin
            stall_left--;
            take = 1'b0;
        end else begin
            take = 1'b1;
            if (!quiet && $urandom_range(99) < 25)
                stall_left = pick_gap(1'b0);
        end
        m_ready <= aresetn && take && hold_left == 0;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    initial begin
        key_pool[0] = '0;
        key_pool[1] = '1;
        for (int i = 2; i < POOL_SIZE; i++)
            key_pool[i] = $urandom();

        queue_request(MODE_LOOKUP, 32'h0000_0000, 32'h0000_0000, '0);
        queue_request(MODE_STORE,  32'h0000_0000, 32'h0000_0000, '0);
        queue_request(MODE_STORE,  32'hFFFF_FFFF, 32'hFFFF_FFFF, TIME_MAX);
        queue_request(MODE_LOOKUP, 32'hFFFF_FFFF, 32'h0000_0000, TIME_MAX);
        queue_request(MODE_LOOKUP, 32'hFFFF_FFFF, 32'h0000_0000, TIME_MAX - 31'd1);
        queue_request(MODE_LOOKUP, 32'h0000_0000, 32'hFFFF_FFFF, TIME_MAX);
        queue_request(MODE_LOOKUP, 32'h1234_5678, 32'h0000_0000, 31'd100);
        queue_request(MODE_STORE,  32'h0000_00A5, 32'h1111_1111, 31'd5);
        queue_request(MODE_STORE,  32'h0000_00A5, 32'h2222_2222, 31'd5);
        queue_request(MODE_LOOKUP, 32'h0000_00A5, 32'h0000_0000, 31'd5);
        queue_request(MODE_STORE,  32'h0000_00A5, 32'h3333_3333, 31'd3);
        queue_request(MODE_LOOKUP, 32'h0000_00A5, 32'h0000_0000, 31'd4);
        queue_request(MODE_LOOKUP, 32'h0000_00A5, 32'h0000_0000, 31'd2);
        queue_request(MODE_LOOKUP, 32'h0000_00A5, 32'h0000_0000, TIME_MAX);
        queue_request(MODE_STORE,  32'h0000_00A5, 32'hAAAA_AAAA, 31'd5);
        queue_request(MODE_LOOKUP, 32'h0000_00A5, 32'h5555_5555, 31'd6);
        queue_request(MODE_STORE,  32'h5555_5555, 32'h5555_5555, 31'h2AAA_AAAA);
        queue_request(MODE_LOOKUP, 32'h5555_5555, 32'hAAAA_AAAA, 31'h5555_5555);
        queue_request(MODE_LOOKUP, 32'hAAAA_AAAA, 32'h0000_0000, 31'h5555_5555);
        for (int i = 0; i < RANDOM_ITEMS; i++)
            pending_requests.insert(pending_requests.size(), random_request());
        total_items = pending_requests.size();

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        while (checked_count < total_items)
            @(posedge aclk);
        repeat (SLOTS + 16) @(posedge aclk);

        if (failures == 0 && expected_results.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// ===== versioned_key_value_lookup.f =====
+incdir+rtl
rtl/vkv_pkg.sv
rtl/vkv_cell.sv
rtl/versioned_key_value_lookup.sv
sim/tb_versioned_key_value_lookup.sv
